### rtl/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg
// Shared constants for the stream prefetch engine: parameter defaults,
// configuration register indexes and register reset values.
// ----------------------------------------------------------------------------
package spe_pkg;

    localparam int TABLE_ENTRIES_DEF     = 64;
    localparam int BLOCK_OFFSET_BITS_DEF = 6;
    localparam int PAGE_OFFSET_BITS_DEF  = 12;

    localparam int ADDR_W   = 64;
    localparam int DEGREE_W = 8;
    localparam int DIST_W   = 12;
    localparam int STAMP_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS    = 2'd2;

    localparam logic [DEGREE_W-1:0] DEGREE_RST   = 8'd100;
    localparam logic [DIST_W-1:0]   DISTANCE_RST = 12'd100;

endpackage

### rtl/stream_prefetch_engine.sv
// ----------------------------------------------------------------------------
// stream_prefetch_engine
// Stream prefetcher: misses train a table of monitored regions, ticks issue
// lookahead prefetch requests one block at a time.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       receive    in_valid / in_stall   cmd, access_addr, was_hit,
//                                           request_accepted, mshr_below_half
// out      send       out_valid / out_stall pf_valid, pf_addr, fill_this_level
// cfg      receive    cfg_we                cfg_index, cfg_data
//
// A tick or a hit is answered from the idle state. A training miss reads the
// region memory through one port: a match scan over the recorded regions,
// and an oldest-stamp scan over all entries when the table is full and a
// new region is recorded. Reset clears the state, configuration, training,
// lookahead and output-valid registers; region memory needs no clearing pass.
// A stalled result holds the output register and blocks the next request.
// ----------------------------------------------------------------------------
module stream_prefetch_engine #(
    parameter int TABLE_ENTRIES     = spe_pkg::TABLE_ENTRIES_DEF,
    parameter int BLOCK_OFFSET_BITS = spe_pkg::BLOCK_OFFSET_BITS_DEF,
    parameter int PAGE_OFFSET_BITS  = spe_pkg::PAGE_OFFSET_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic [spe_pkg::ADDR_W-1:0]        access_addr,
    input  logic                              was_hit,
    input  logic                              request_accepted,
    input  logic                              mshr_below_half,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              pf_valid,
    output logic [spe_pkg::ADDR_W-1:0]        pf_addr,
    output logic                              fill_this_level,
    input  logic                              cfg_we,
    input  logic [spe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spe_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int BW  = spe_pkg::ADDR_W - BLOCK_OFFSET_BITS;
    localparam int PGS = PAGE_OFFSET_BITS - BLOCK_OFFSET_BITS;
    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int SW  = spe_pkg::STAMP_W;
    localparam int EW  = BW + 1 + SW;
    localparam logic [CW-1:0] ENTRIES = CW'(TABLE_ENTRIES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MATCH = 3'd1;
    localparam logic [2:0] S_HITWR = 3'd2;
    localparam logic [2:0] S_MIN   = 3'd3;
    localparam logic [2:0] S_NEWWR = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [spe_pkg::DEGREE_W-1:0]   degree_reg;
    logic [spe_pkg::DIST_W-1:0]     distance_reg;
    logic                           cross_reg;

    logic [BW-1:0]                  last_block_reg, last_block_next;
    logic signed [BW:0]             last_step_reg, last_step_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [SW-1:0]                  stamp_reg, stamp_next;
    logic                           la_active_reg, la_active_next;
    logic [BW-1:0]                  la_block_reg, la_block_next;
    logic                           la_down_reg, la_down_next;
    logic [spe_pkg::DEGREE_W-1:0]   la_left_reg, la_left_next;

    logic [BW-1:0]                  b_reg, b_next;
    logic                           b_down_reg, b_down_next;
    logic                           new_cond_reg, new_cond_next;
    logic [CW-1:0]                  ptr_reg, ptr_next;
    logic                           rvld_reg;
    logic [IW-1:0]                  ridx_reg;
    logic [EW-1:0]                  rdata_reg;
    logic [IW-1:0]                  sel_reg, sel_next;
    logic [BW-1:0]                  sel_start_reg, sel_start_next;
    logic                           sel_down_reg, sel_down_next;
    logic [SW-1:0]                  min_stamp_reg, min_stamp_next;
    logic                           min_first_reg, min_first_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           pf_valid_reg, pf_valid_next;
    logic [spe_pkg::ADDR_W-1:0]     pf_addr_reg, pf_addr_next;
    logic                           fill_reg, fill_next;

    logic [EW-1:0]                  mem [TABLE_ENTRIES];
    logic                           mem_we;
    logic [IW-1:0]                  mem_waddr;
    logic [EW-1:0]                  mem_wdata;
    logic                           issue;

    logic                           in_fire, out_free;
    logic [BW-1:0]                  blk;
    logic signed [BW:0]             step;
    logic signed [BW+1:0]           step_sum;
    logic [BW-1:0]                  r_start;
    logic                           r_down;
    logic [SW-1:0]                  r_stamp;
    logic [BW-1:0]                  dist_ext, deg_ext;
    logic                           hit;
    logic [BW-1:0]                  la_nxt;
    logic                           la_ok;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign in_fire  = in_valid && !in_stall;

    assign blk      = access_addr[spe_pkg::ADDR_W-1:BLOCK_OFFSET_BITS];
    assign step     = $signed({1'b0, blk}) - $signed({1'b0, last_block_reg});
    assign step_sum = (BW+2)'(step) + (BW+2)'(last_step_reg);

    assign r_start  = rdata_reg[EW-1:SW+1];
    assign r_down   = rdata_reg[SW];
    assign r_stamp  = rdata_reg[SW-1:0];
    assign dist_ext = BW'(distance_reg);
    assign deg_ext  = BW'(degree_reg);
    assign hit = r_down ? ((b_reg <= r_start) && ((r_start - b_reg) < dist_ext))
                        : ((b_reg >= r_start) && ((b_reg - r_start) < dist_ext));

    assign la_nxt = la_down_reg ? (la_block_reg - 1'b1) : (la_block_reg + 1'b1);
    assign la_ok  = cross_reg || (la_nxt[BW-1:PGS] == la_block_reg[BW-1:PGS]);

    always_comb
    begin
        state_next      = state_reg;
        last_block_next = last_block_reg;
        last_step_next  = last_step_reg;
        count_next      = count_reg;
        stamp_next      = stamp_reg;
        la_active_next  = la_active_reg;
        la_block_next   = la_block_reg;
        la_down_next    = la_down_reg;
        la_left_next    = la_left_reg;
        b_next          = b_reg;
        b_down_next     = b_down_reg;
        new_cond_next   = new_cond_reg;
        ptr_next        = ptr_reg;
        sel_next        = sel_reg;
        sel_start_next  = sel_start_reg;
        sel_down_next   = sel_down_reg;
        min_stamp_next  = min_stamp_reg;
        min_first_next  = min_first_reg;
        out_valid_next  = out_valid_reg && out_stall;
        pf_valid_next   = pf_valid_reg;
        pf_addr_next    = pf_addr_reg;
        fill_next       = fill_reg;
        mem_we          = 1'b0;
        mem_waddr       = sel_reg;
        mem_wdata       = '0;
        issue           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (cmd)
                    begin
                        out_valid_next = 1'b1;
                        pf_valid_next  = 1'b0;
                        pf_addr_next   = '0;
                        fill_next      = 1'b0;
                        if (la_active_reg)
                        begin
                            if (la_ok)
                            begin
                                pf_valid_next = 1'b1;
                                pf_addr_next  = {la_nxt, {BLOCK_OFFSET_BITS{1'b0}}};
                                fill_next     = mshr_below_half;
                                if (request_accepted)
                                begin
                                    la_block_next = la_nxt;
                                    if (la_left_reg <= 8'd1)
                                    begin
                                        la_left_next   = '0;
                                        la_active_next = 1'b0;
                                    end
                                    else
                                    begin
                                        la_left_next = la_left_reg - 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                la_active_next = 1'b0;
                            end
                        end
                    end
                    else if (was_hit
                             || (last_block_reg == '0 && last_step_reg == '0))
                    begin
                        out_valid_next = 1'b1;
                        pf_valid_next  = 1'b0;
                        pf_addr_next   = '0;
                        fill_next      = 1'b0;
                        if (!was_hit)
                        begin
                            last_step_next  = '0;
                            last_block_next = blk;
                        end
                    end
                    else
                    begin
                        b_next        = blk;
                        b_down_next   = step < 0;
                        new_cond_next = ((step > 0 && last_step_reg > 0)
                                         || (step < 0 && last_step_reg < 0))
                                        && (step_sum < $signed({1'b0, dist_ext, 1'b0}) >>> 1);
                        last_step_next  = (last_block_reg == '0) ? '0 : step;
                        last_block_next = blk;
                        ptr_next        = '0;
                        state_next      = S_MATCH;
                    end
                end
            end
            S_MATCH:
            begin
                issue = ptr_reg < count_reg;
                if (issue)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (rvld_reg && hit)
                begin
                    sel_next       = ridx_reg;
                    sel_start_next = r_start;
                    sel_down_next  = r_down;
                    state_next     = S_HITWR;
                end
                else if (!issue && !rvld_reg)
                begin
                    ptr_next       = '0;
                    min_first_next = 1'b1;
                    if (!new_cond_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else if (count_reg < ENTRIES)
                    begin
                        sel_next   = count_reg[IW-1:0];
                        count_next = count_reg + 1'b1;
                        state_next = S_NEWWR;
                    end
                    else
                    begin
                        state_next = S_MIN;
                    end
                end
            end
            S_HITWR:
            begin
                stamp_next = stamp_reg + 1'b1;
                mem_we     = 1'b1;
                mem_wdata  = {sel_down_reg ? (sel_start_reg - deg_ext)
                                           : (sel_start_reg + deg_ext),
                              sel_down_reg, stamp_next};
                if (degree_reg != '0)
                begin
                    la_active_next = 1'b1;
                    la_down_next   = sel_down_reg;
                    la_block_next  = sel_down_reg ? (sel_start_reg - dist_ext)
                                                  : (sel_start_reg + dist_ext);
                    la_left_next   = degree_reg;
                end
                else
                begin
                    la_active_next = 1'b0;
                end
                ptr_next       = '0;
                min_first_next = 1'b1;
                if (!new_cond_reg)
                begin
                    state_next = S_DONE;
                end
                else if (count_reg < ENTRIES)
                begin
                    sel_next   = count_reg[IW-1:0];
                    count_next = count_reg + 1'b1;
                    state_next = S_NEWWR;
                end
                else
                begin
                    state_next = S_MIN;
                end
            end
            S_MIN:
            begin
                issue = ptr_reg < ENTRIES;
                if (issue)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (rvld_reg && (min_first_reg || r_stamp < min_stamp_reg))
                begin
                    min_first_next = 1'b0;
                    min_stamp_next = r_stamp;
                    sel_next       = ridx_reg;
                end
                if (!issue && !rvld_reg)
                begin
                    state_next = S_NEWWR;
                end
            end
            S_NEWWR:
            begin
                stamp_next = stamp_reg + 1'b1;
                mem_we     = 1'b1;
                mem_wdata  = {b_reg, b_down_reg, stamp_next};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    pf_valid_next  = 1'b0;
                    pf_addr_next   = '0;
                    fill_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[ptr_reg[IW-1:0]];
        ridx_reg  <= ptr_reg[IW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            degree_reg     <= spe_pkg::DEGREE_RST;
            distance_reg   <= spe_pkg::DISTANCE_RST;
            cross_reg      <= 1'b0;
            last_block_reg <= '0;
            last_step_reg  <= '0;
            count_reg      <= '0;
            stamp_reg      <= '0;
            la_active_reg  <= 1'b0;
            la_block_reg   <= '0;
            la_down_reg    <= 1'b0;
            la_left_reg    <= '0;
            rvld_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_block_reg <= last_block_next;
            last_step_reg  <= last_step_next;
            count_reg      <= count_next;
            stamp_reg      <= stamp_next;
            la_active_reg  <= la_active_next;
            la_block_reg   <= la_block_next;
            la_down_reg    <= la_down_next;
            la_left_reg    <= la_left_next;
            rvld_reg       <= issue && !(state_reg == S_MATCH && rvld_reg && hit);
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    spe_pkg::CFG_DEGREE:   degree_reg   <= cfg_data[spe_pkg::DEGREE_W-1:0];
                    spe_pkg::CFG_DISTANCE: distance_reg <= cfg_data;
                    spe_pkg::CFG_CROSS:    cross_reg    <= cfg_data[0];
                    default:               cross_reg    <= cross_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg         <= b_next;
        b_down_reg    <= b_down_next;
        new_cond_reg  <= new_cond_next;
        ptr_reg       <= ptr_next;
        sel_reg       <= sel_next;
        sel_start_reg <= sel_start_next;
        sel_down_reg  <= sel_down_next;
        min_stamp_reg <= min_stamp_next;
        min_first_reg <= min_first_next;
        pf_valid_reg  <= pf_valid_next;
        pf_addr_reg   <= pf_addr_next;
        fill_reg      <= fill_next;
    end

    assign out_valid       = out_valid_reg;
    assign pf_valid        = pf_valid_reg;
    assign pf_addr         = pf_addr_reg;
    assign fill_this_level = fill_reg;

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("request taken while a miss is in training");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ENTRIES)
        else $error("region count above table size");

    a_new_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NEWWR) |=> (stamp_reg == $past(stamp_reg) + 1'b1))
        else $error("new region did not advance the stamp");

    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && !pf_valid_reg))
        else $error("training miss ended without an empty result");

endmodule

### dv/spe_checker.sv
// ----------------------------------------------------------------------------
// spe_checker
// Watches the request and result channels of the stream prefetch engine,
// predicts each result from its own copy of the region table, lookahead
// and registers, and compares every field of every result in order.
// ----------------------------------------------------------------------------
module spe_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           cmd,
    input  logic [spe_pkg::ADDR_W-1:0]     access_addr,
    input  logic                           was_hit,
    input  logic                           request_accepted,
    input  logic                           mshr_below_half,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           pf_valid,
    input  logic [spe_pkg::ADDR_W-1:0]     pf_addr,
    input  logic                           fill_this_level,
    input  logic                           cfg_we,
    input  logic [spe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spe_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = spe_pkg::TABLE_ENTRIES_DEF;
    localparam int BOB     = spe_pkg::BLOCK_OFFSET_BITS_DEF;
    localparam int BW      = spe_pkg::ADDR_W - BOB;
    localparam int PGS     = spe_pkg::PAGE_OFFSET_BITS_DEF - BOB;

    typedef struct packed {
        logic                      valid;
        logic [spe_pkg::ADDR_W-1:0] addr;
        logic                      fill;
    } prefetch_t;

    logic [spe_pkg::DEGREE_W-1:0] degree;
    logic [spe_pkg::DIST_W-1:0]   distance;
    logic                         cross_ok;
    logic [BW-1:0]                prev_block;
    logic signed [BW:0]           prev_step;
    logic [BW-1:0]                reg_start [ENTRIES];
    logic                         reg_down [ENTRIES];
    logic [31:0]                  reg_stamp [ENTRIES];
    int                           reg_used;
    logic [31:0]                  stamp;
    logic                         la_on;
    logic [BW-1:0]                la_blk;
    logic                         la_dn;
    logic [7:0]                   la_cnt;
    prefetch_t                    expected_q[$];
    int                           mismatches;

    assign fail_count    = mismatches;
    assign pending_count = expected_q.size();

    task automatic train_on_miss(input logic [BW-1:0] b);
        logic signed [BW:0] step;
        logic signed [BW+1:0] sum;
        int slot;
        logic hit;
        logic [BW-1:0] s;
        if (prev_block == 0 && prev_step == 0)
            return;
        step = $signed({1'b0, b}) - $signed({1'b0, prev_block});
        for (int i = 0; i < reg_used; i++)
        begin
            s = reg_start[i];
            if (reg_down[i])
                hit = (b <= s) && ((s - b) < distance);
            else
                hit = (b >= s) && ((b - s) < distance);
            if (hit)
            begin
                if (degree != 0)
                begin
                    la_on  = 1'b1;
                    la_dn  = reg_down[i];
                    la_blk = reg_down[i] ? s - distance : s + distance;
                    la_cnt = degree;
                end
                else
                    la_on = 1'b0;
                reg_start[i] = reg_down[i] ? s - degree : s + degree;
                stamp = stamp + 1;
                reg_stamp[i] = stamp;
                break;
            end
        end
        sum = step + prev_step;
        if (((step > 0 && prev_step > 0) || (step < 0 && prev_step < 0))
            && sum < $signed({1'b0, distance}))
        begin
            stamp = stamp + 1;
            if (reg_used < ENTRIES)
            begin
                slot = reg_used;
                reg_used++;
            end
            else
            begin
                slot = 0;
                for (int j = 1; j < ENTRIES; j++)
                    if (reg_stamp[j] < reg_stamp[slot])
                        slot = j;
            end
            reg_start[slot] = b;
            reg_down[slot]  = step < 0;
            reg_stamp[slot] = stamp;
        end
    endtask

    function automatic prefetch_t issue_on_tick(input logic taken, input logic fill);
        prefetch_t r;
        logic [BW-1:0] nxt;
        r = '0;
        if (la_on)
        begin
            nxt = la_dn ? la_blk - 1 : la_blk + 1;
            if (cross_ok || (nxt >> PGS) == (la_blk >> PGS))
            begin
                r.valid = 1'b1;
                r.addr  = {nxt, {BOB{1'b0}}};
                r.fill  = fill;
                if (taken)
                begin
                    la_blk = nxt;
                    if (la_cnt > 0)
                        la_cnt--;
                    if (la_cnt == 0)
                        la_on = 1'b0;
                end
            end
            else
                la_on = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        prefetch_t got;
        prefetch_t want;
        logic [BW-1:0] b;
        if (!rst_n)
        begin
            degree     = spe_pkg::DEGREE_RST;
            distance   = spe_pkg::DISTANCE_RST;
            cross_ok   = 1'b0;
            prev_block = '0;
            prev_step  = '0;
            reg_used   = 0;
            stamp      = '0;
            la_on      = 1'b0;
            la_blk     = '0;
            la_dn      = 1'b0;
            la_cnt     = '0;
            mismatches = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    spe_pkg::CFG_DEGREE:   degree   = cfg_data[spe_pkg::DEGREE_W-1:0];
                    spe_pkg::CFG_DISTANCE: distance = cfg_data;
                    spe_pkg::CFG_CROSS:    cross_ok = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got = '{pf_valid, pf_addr, fill_this_level};
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: valid %0b addr %h fill %0b",
                                 pf_valid, pf_addr, fill_this_level);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %0b %h %0b, got %0b %h %0b",
                                     want.valid, want.addr, want.fill,
                                     got.valid, got.addr, got.fill);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (cmd == 1'b0)
                begin
                    if (!was_hit)
                    begin
                        b = access_addr[spe_pkg::ADDR_W-1:BOB];
                        train_on_miss(b);
                        prev_step = (prev_block == 0) ? '0
                            : $signed({1'b0, b}) - $signed({1'b0, prev_block});
                        prev_block = b;
                    end
                    expected_q.insert(expected_q.size(), prefetch_t'('0));
                end
                else
                    expected_q.insert(expected_q.size(),
                                      issue_on_tick(request_accepted, mshr_below_half));
            end
        end
    end
endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the stream prefetch engine: directed and random streams of
// misses, hits and ticks under several register settings, with bursty
// requests and random result stalls. Checking is done by spe_checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic                           cmd;
    logic [spe_pkg::ADDR_W-1:0]     access_addr;
    logic                           was_hit;
    logic                           request_accepted;
    logic                           mshr_below_half;
    logic                           out_valid;
    logic                           out_stall;
    logic                           pf_valid;
    logic [spe_pkg::ADDR_W-1:0]     pf_addr;
    logic                           fill_this_level;
    logic                           cfg_we;
    logic [spe_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [spe_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             fail_count;
    int                             pending_count;
    int                             idle_cycles;
    int                             burst_left;
    int                             stall_mode;
    logic [57:0]                    stream_block;

    stream_prefetch_engine dut (.*);
    spe_checker checker_i (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(3) == 0);
            default: out_stall <= ($urandom_range(3) != 0);
        endcase
        if ($urandom_range(63) == 0)
            stall_mode <= $urandom_range(2);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("stream_prefetch_engine verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [spe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [spe_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send(input logic c, input logic [63:0] a, input logic h,
                        input logic acc, input logic fill);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid         <= 1'b1;
        cmd              <= c;
        access_addr      <= a;
        was_hit          <= h;
        request_accepted <= acc;
        mshr_below_half  <= fill;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic miss(input logic [57:0] b);
        send(1'b0, {b, 6'($urandom)}, 1'b0, 1'($urandom), 1'($urandom));
    endtask

    task automatic tick();
        send(1'b1, {$urandom, $urandom}, 1'($urandom), ($urandom_range(3) != 0),
             1'($urandom));
    endtask

    task automatic random_phase(input int n);
        int k;
        int step;
        int dir;
        k = 0;
        while (k < n)
        begin
            case ($urandom_range(9))
                0:
                begin
                    send(1'b0, {$urandom, $urandom}, 1'b0, 1'($urandom), 1'($urandom));
                    k++;
                end
                1: send(1'b0, {$urandom, $urandom}, 1'b1, 1'($urandom), 1'($urandom));
                2, 3, 4:
                begin
                    stream_block = ($urandom_range(3) == 0) ? 58'($urandom_range(2, 300))
                        : 58'({$urandom, $urandom});
                    dir  = $urandom_range(1);
                    step = $urandom_range(1, 4);
                    repeat ($urandom_range(3, 6))
                    begin
                        miss(stream_block);
                        stream_block = (dir != 0) ? stream_block - 58'(step)
                                                  : stream_block + 58'(step);
                        k++;
                    end
                end
                default:
                begin
                    repeat ($urandom_range(1, 8))
                    begin
                        tick();
                        k++;
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        stall_mode = 0;
        cmd = 1'b0;
        access_addr = '0;
        was_hit = 1'b0;
        request_accepted = 1'b0;
        mshr_below_half = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        idle_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first miss, up and down streams, ticks with rejects.
        tick();
        send(1'b0, '1, 1'b1, 1'b1, 1'b1);
        miss(58'd1000);
        miss(58'd1001);
        miss(58'd1002);
        miss(58'd1003);
        send(1'b1, '0, 1'b0, 1'b0, 1'b1);
        send(1'b1, '1, 1'b1, 1'b1, 1'b0);
        repeat (4) send(1'b1, '0, 1'b0, 1'b1, 1'b1);
        miss(58'h3FFFFFFFFFFFFFF);
        miss(58'h3FFFFFFFFFFFFFD);
        miss(58'h3FFFFFFFFFFFFFB);
        miss(58'h3FFFFFFFFFFFFFA);
        repeat (4) send(1'b1, '1, 1'b0, 1'b1, 1'b0);
        miss(58'd0);
        miss(58'd2);
        drain();

        write_reg(spe_pkg::CFG_DEGREE, 12'd255);
        write_reg(spe_pkg::CFG_DISTANCE, 12'd4095);
        write_reg(spe_pkg::CFG_CROSS, 12'd1);
        random_phase(100);
        drain();

        write_reg(spe_pkg::CFG_DEGREE, 12'd0);
        write_reg(spe_pkg::CFG_DISTANCE, 12'd0);
        write_reg(spe_pkg::CFG_CROSS, 12'd0);
        random_phase(40);
        drain();

        write_reg(spe_pkg::CFG_DEGREE, 12'd1);
        write_reg(spe_pkg::CFG_DISTANCE, 12'd1);
        write_reg(spe_pkg::CFG_CROSS, 12'd1);
        random_phase(60);
        drain();

        write_reg(spe_pkg::CFG_DEGREE, 12'($urandom_range(2, 40)));
        write_reg(spe_pkg::CFG_DISTANCE, 12'($urandom_range(8, 600)));
        write_reg(spe_pkg::CFG_CROSS, 12'($urandom_range(1)));
        random_phase(200);
        drain();

        if (fail_count == 0)
            $display("stream_prefetch_engine verification clean");
        else
            $display("stream_prefetch_engine verification failed");
        $finish;
    end
endmodule
